// ===== src/bst_pkg.sv =====
// shared types, constants and keyword table for the source tokenizer
// no dependencies
package bst_pkg;

    localparam int DEF_MAX_SOURCE_BYTES    = 65536;
    localparam int DEF_MAX_FRACTION_DIGITS = 18;
    localparam int IDENT_DEPTH             = 7;
    localparam int KW_COUNT                = 23;

    localparam logic [62:0] INT_MAX63 = {63{1'b1}};

    // token kinds
    localparam logic [3:0] TK_END     = 4'd0;
    localparam logic [3:0] TK_NUMBER  = 4'd1;
    localparam logic [3:0] TK_STRING  = 4'd2;
    localparam logic [3:0] TK_IDENT   = 4'd3;
    localparam logic [3:0] TK_KEYWORD = 4'd4;
    localparam logic [3:0] TK_LPAREN  = 4'd5;
    localparam logic [3:0] TK_RPAREN  = 4'd6;
    localparam logic [3:0] TK_COMMA   = 4'd7;
    localparam logic [3:0] TK_SEMI    = 4'd8;
    localparam logic [3:0] TK_COLON   = 4'd9;
    localparam logic [3:0] TK_NEWLINE = 4'd10;
    localparam logic [3:0] TK_OP      = 4'd11;
    localparam logic [3:0] TK_ERROR   = 4'd12;

    // operator codes
    localparam logic [2:0] OP_PLUS  = 3'd0;
    localparam logic [2:0] OP_MINUS = 3'd1;
    localparam logic [2:0] OP_TIMES = 3'd2;
    localparam logic [2:0] OP_DIV   = 3'd3;
    localparam logic [2:0] OP_EQ    = 3'd4;
    localparam logic [2:0] OP_LT    = 3'd5;
    localparam logic [2:0] OP_GT    = 3'd6;

    // input kinds
    localparam logic IN_BYTE = 1'b0;
    localparam logic IN_END  = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_NUM  = 4'b0010,
        ST_STR  = 4'b0100,
        ST_ID   = 4'b1000
    } t_mode;

    typedef struct packed {
        logic [3:0]  token_kind;
        logic [4:0]  keyword_code;
        logic [2:0]  operator_code;
        logic [62:0] integer_part;
        logic [59:0] fraction_digits;
        logic [4:0]  fraction_count;
        logic        has_point;
        logic [15:0] start_offset;
        logic [15:0] token_length;
        logic [15:0] line_number;
    } t_tok;

    // front to back: the tokens one input word produced
    typedef struct packed {
        logic [1:0] cnt;
        t_tok       t0;
        t_tok       t1;
    } t_pair;

    // saturation limits (INT_MAX63 - d) / 10 for digit d
    localparam logic [62:0] SAT_LIM [10] = '{
        (INT_MAX63 - 63'd0) / 63'd10, (INT_MAX63 - 63'd1) / 63'd10,
        (INT_MAX63 - 63'd2) / 63'd10, (INT_MAX63 - 63'd3) / 63'd10,
        (INT_MAX63 - 63'd4) / 63'd10, (INT_MAX63 - 63'd5) / 63'd10,
        (INT_MAX63 - 63'd6) / 63'd10, (INT_MAX63 - 63'd7) / 63'd10,
        (INT_MAX63 - 63'd8) / 63'd10, (INT_MAX63 - 63'd9) / 63'd10
    };

    // keyword text, first char in the low byte
    function automatic logic [55:0] kw_text(input logic [4:0] i);
        logic [55:0] t;
        case (i)
            5'd0:  t = {"TNIRP"};
            5'd1:  t = {"TEL"};
            5'd2:  t = {"OTOG"};
            5'd3:  t = {"BUSOG"};
            5'd4:  t = {"NRUTER"};
            5'd5:  t = {"ROF"};
            5'd6:  t = {"OT"};
            5'd7:  t = {"PETS"};
            5'd8:  t = {"TXEN"};
            5'd9:  t = {"FI"};
            5'd10: t = {"NEHT"};
            5'd11: t = {"ESLE"};
            5'd12: t = {"DNE"};
            5'd13: t = {"POTS"};
            5'd14: t = {"TUPNI"};
            5'd15: t = {"DAER"};
            5'd16: t = {"ATAD"};
            5'd17: t = {"EROTSER"};
            5'd18: t = {"MID"};
            5'd19: t = {"MER"};
            5'd20: t = {"NO"};
            5'd21: t = {"FED"};
            5'd22: t = {"NF"};
            default: t = '0;
        endcase
        return t;
    endfunction

    function automatic logic [2:0] kw_len(input logic [4:0] i);
        logic [2:0] l;
        case (i)
            5'd0, 5'd3, 5'd14:                               l = 3'd5;
            5'd4:                                            l = 3'd6;
            5'd17:                                           l = 3'd7;
            5'd6, 5'd9, 5'd20, 5'd22:                        l = 3'd2;
            5'd1, 5'd5, 5'd12, 5'd18, 5'd19, 5'd21:          l = 3'd3;
            default:                                         l = 3'd4;
        endcase
        return l;
    endfunction

    // keyword code 1..23 or 0
    function automatic logic [4:0] kw_match(input logic [2:0] len, input logic [55:0] chars);
        logic [4:0]  code;
        logic [55:0] mask;
        code = '0;
        mask = ~(56'hFF_FFFF_FFFF_FFFF << {len, 3'b000});
        for (int i = 0; i < KW_COUNT; i++) begin
            if (kw_len(5'(i)) == len && ((kw_text(5'(i)) ^ chars) & mask) == '0)
                code = 5'(i + 1);
        end
        return code;
    endfunction

endpackage

// ===== src/bst_if.sv =====
// channel interfaces of the source tokenizer: source bytes in, tokens out
// no dependencies
interface bst_src_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] ch;
    modport source (output valid, kind, ch, input ready);
    modport sink (input valid, kind, ch, output ready);
endinterface

interface bst_tok_if;
    logic        valid;
    logic        ready;
    logic [3:0]  token_kind;
    logic [4:0]  keyword_code;
    logic [2:0]  operator_code;
    logic [62:0] integer_part;
    logic [59:0] fraction_digits;
    logic [4:0]  fraction_count;
    logic        has_point;
    logic [15:0] start_offset;
    logic [15:0] token_length;
    logic [15:0] line_number;
    logic        last_of_run;
    modport source (output valid, token_kind, keyword_code, operator_code, integer_part,
                    fraction_digits, fraction_count, has_point, start_offset,
                    token_length, line_number, last_of_run, input ready);
    modport sink (input valid, token_kind, keyword_code, operator_code, integer_part,
                  fraction_digits, fraction_count, has_point, start_offset,
                  token_length, line_number, last_of_run, output ready);
endinterface

// ===== src/basic_source_tokenizer.sv =====
// streaming source tokenizer top level: front scanner, pair queue, token output
// depends on bst_pkg, bst_if, bst_front, bst_queue, bst_back
//
// i_src carries one source byte (kind 0) or an end mark (kind 1) per word.
// o_tok carries one token word: kind, keyword and operator codes, number
// fields, start offset, length and line, plus last_of_run on the final
// token a source word caused. An input word produces zero, one or two tokens.
// throughput: one source word per cycle while the pair queue has room; a word
// that finishes two tokens gives the back end two tokens to send from one
// queue entry, absorbed by the two-entry pair queue, so the input stalls only
// when such words fill the queue or when the receiver holds ready low.
// the scanner writes the pair queue at the edge that accepts the word, and
// the output register loads from the queue head once it is free, so the first
// token of a word reaches o_tok ahead of the second.
// i_src.ready is high while the pair queue has room; it does not depend on
// o_tok.ready within the same cycle.
// reset (synchronous, active low) returns the scanner to idle at offset 0,
// line 1, and empties the queue and output register.
// a stalled receiver holds the output word stable; the queue fills, then
// i_src.ready drops.
// offsets wrap modulo MAX_SOURCE_BYTES; after an end mark a new source starts.
module basic_source_tokenizer import bst_pkg::*; #(
    parameter int MAX_SOURCE_BYTES    = DEF_MAX_SOURCE_BYTES,
    parameter int MAX_FRACTION_DIGITS = DEF_MAX_FRACTION_DIGITS
) (
    input logic      i_clk,
    input logic      i_rst_n,
    bst_src_if.sink  i_src,
    bst_tok_if.source o_tok
);
    logic  acc, push, pop, full, empty, last;
    t_pair pair, head;
    t_tok  tok;

    // accept whenever the queue can take a pair
    assign i_src.ready = !full;
    assign acc         = i_src.valid && !full;

    bst_front #(
        .MAX_SOURCE_BYTES   (MAX_SOURCE_BYTES),
        .MAX_FRACTION_DIGITS(MAX_FRACTION_DIGITS)
    ) u_front (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_acc  (acc),
        .i_kind (i_src.kind),
        .i_ch   (i_src.ch),
        .o_push (push),
        .o_pair (pair)
    );

    bst_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_pair (pair),
        .i_pop  (pop),
        .o_full (full),
        .o_empty(empty),
        .o_head (head)
    );

    bst_back u_back (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_empty(empty),
        .i_head (head),
        .o_pop  (pop),
        .o_valid(o_tok.valid),
        .i_ready(o_tok.ready),
        .o_tok  (tok),
        .o_last (last)
    );

    // unpack the output word
    assign o_tok.token_kind      = tok.token_kind;
    assign o_tok.keyword_code    = tok.keyword_code;
    assign o_tok.operator_code   = tok.operator_code;
    assign o_tok.integer_part    = tok.integer_part;
    assign o_tok.fraction_digits = tok.fraction_digits;
    assign o_tok.fraction_count  = tok.fraction_count;
    assign o_tok.has_point       = tok.has_point;
    assign o_tok.start_offset    = tok.start_offset;
    assign o_tok.token_length    = tok.token_length;
    assign o_tok.line_number     = tok.line_number;
    assign o_tok.last_of_run     = last;

endmodule

// ===== src/bst_front.sv =====
// front end: scan state machine, builds the tokens each source word finishes
// depends on bst_pkg
module bst_front import bst_pkg::*; #(
    parameter int MAX_SOURCE_BYTES    = DEF_MAX_SOURCE_BYTES,
    parameter int MAX_FRACTION_DIGITS = DEF_MAX_FRACTION_DIGITS
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_acc,
    input  logic       i_kind,
    input  logic [7:0] i_ch,
    output logic       o_push,
    output t_pair      o_pair
);
    localparam int          PW    = $clog2(MAX_SOURCE_BYTES);
    localparam logic [PW:0] MAXV  = (PW + 1)'(MAX_SOURCE_BYTES);
    localparam logic [PW-1:0] LAST = PW'(MAX_SOURCE_BYTES - 1);
    localparam logic [4:0]  FMAX  = 5'(MAX_FRACTION_DIGITS);

    t_mode         r_mode, n_mode;
    logic [PW-1:0] r_pos, n_pos;
    logic [15:0]   r_line, n_line;
    logic [PW-1:0] r_start, n_start;
    logic [62:0]   r_int, n_int;
    logic [59:0]   r_frac, n_frac;
    logic [4:0]    r_fcnt, n_fcnt;
    logic          r_pt, n_pt;
    logic          r_long, n_long;
    logic [7:0]    r_chars [IDENT_DEPTH];

    logic [PW-1:0]  span, pos_inc, pos1;
    logic [PW:0]    span_w;
    logic [PW+15:0] span_x, start_x, pos_x;
    logic [3:0]     dig;
    logic           is_dig, is_alpha, is_idch;
    logic           il_emit;
    t_tok           il_tok, num_tok, id_tok, str_tok, end_tok, close_tok;
    logic           has_close, lex_now, wr_ch;
    logic [55:0]    chars_flat;
    logic [4:0]     kw;
    logic [62:0]    int_mul;

    assign span_w  = {1'b0, r_pos} + ((r_pos < r_start) ? MAXV : '0) - {1'b0, r_start};
    assign span    = span_w[PW-1:0];
    assign span_x  = {16'b0, span};
    assign start_x = {16'b0, r_start};
    assign pos_x   = {16'b0, r_pos};
    assign pos_inc = (r_pos == LAST) ? '0 : r_pos + 1'b1;
    assign pos1    = pos_inc;

    assign is_dig   = i_ch >= "0" && i_ch <= "9";
    assign dig      = i_ch[3:0];
    assign is_alpha = (i_ch >= "a" && i_ch <= "z") || (i_ch >= "A" && i_ch <= "Z");
    assign is_idch  = is_alpha || is_dig || i_ch == "$" || i_ch == "_";

    always_comb begin
        for (int i = 0; i < IDENT_DEPTH; i++) chars_flat[i*8 +: 8] = r_chars[i];
    end
    assign kw = (!r_long && span_x[15:0] <= 16'(IDENT_DEPTH)) ?
                kw_match(span_x[2:0], chars_flat) : '0;

    assign int_mul = (r_int << 3) + (r_int << 1) + 63'(dig);

    // tokens that close an open scan, and the end token
    always_comb begin
        num_tok = '0;
        num_tok.token_kind      = TK_NUMBER;
        num_tok.integer_part    = r_int;
        num_tok.fraction_digits = r_frac;
        num_tok.fraction_count  = r_fcnt;
        num_tok.has_point       = r_pt;
        num_tok.start_offset    = start_x[15:0];
        num_tok.token_length    = span_x[15:0];
        num_tok.line_number     = r_line;
        id_tok = '0;
        id_tok.token_kind   = (kw != '0) ? TK_KEYWORD : TK_IDENT;
        id_tok.keyword_code = kw;
        id_tok.start_offset = start_x[15:0];
        id_tok.token_length = span_x[15:0];
        id_tok.line_number  = r_line;
        str_tok = '0;
        str_tok.token_kind   = TK_STRING;
        str_tok.start_offset = start_x[15:0];
        str_tok.token_length = span_x[15:0];
        str_tok.line_number  = r_line;
        end_tok = '0;
        end_tok.token_kind   = TK_END;
        end_tok.start_offset = pos_x[15:0];
        end_tok.line_number  = r_line;
    end

    // one-byte tokens from idle
    always_comb begin
        il_tok = '0;
        il_tok.start_offset = pos_x[15:0];
        il_tok.token_length = 16'd1;
        il_tok.line_number  = r_line;
        il_emit = 1'b1;
        if (i_ch == " " || i_ch == 8'h09 || i_ch == 8'h0D || is_dig || is_alpha || i_ch == "\"")
            il_emit = 1'b0;
        case (i_ch)
            "(":   il_tok.token_kind = TK_LPAREN;
            ")":   il_tok.token_kind = TK_RPAREN;
            ",":   il_tok.token_kind = TK_COMMA;
            ";":   il_tok.token_kind = TK_SEMI;
            ":":   il_tok.token_kind = TK_COLON;
            8'h0A: il_tok.token_kind = TK_NEWLINE;
            "+": begin il_tok.token_kind = TK_OP; il_tok.operator_code = OP_PLUS;  end
            "-": begin il_tok.token_kind = TK_OP; il_tok.operator_code = OP_MINUS; end
            "*": begin il_tok.token_kind = TK_OP; il_tok.operator_code = OP_TIMES; end
            "/": begin il_tok.token_kind = TK_OP; il_tok.operator_code = OP_DIV;   end
            "=": begin il_tok.token_kind = TK_OP; il_tok.operator_code = OP_EQ;    end
            "<": begin il_tok.token_kind = TK_OP; il_tok.operator_code = OP_LT;    end
            ">": begin il_tok.token_kind = TK_OP; il_tok.operator_code = OP_GT;    end
            default: il_tok.token_kind = TK_ERROR;
        endcase
    end

    always_comb begin
        n_mode = r_mode; n_pos = r_pos; n_line = r_line; n_start = r_start;
        n_int = r_int; n_frac = r_frac; n_fcnt = r_fcnt; n_pt = r_pt; n_long = r_long;
        has_close = 1'b0; close_tok = num_tok; lex_now = 1'b0; wr_ch = 1'b0;
        o_pair = '0;
        if (i_kind == IN_END) begin
            case (r_mode)
                ST_NUM:  begin has_close = 1'b1; close_tok = num_tok; end
                ST_ID:   begin has_close = 1'b1; close_tok = id_tok;  end
                ST_STR:  begin has_close = 1'b1; close_tok = str_tok; end
                default: has_close = 1'b0;
            endcase
            if (has_close) begin
                o_pair.t0 = close_tok; o_pair.t1 = end_tok; o_pair.cnt = 2'd2;
            end else begin
                o_pair.t0 = end_tok; o_pair.cnt = 2'd1;
            end
            n_mode = ST_IDLE; n_pos = '0; n_line = 16'd1;
        end else begin
            case (r_mode)
                ST_NUM: begin
                    if (is_dig) begin
                        if (!r_pt) begin
                            n_int = (r_int > SAT_LIM[dig]) ? INT_MAX63 : int_mul;
                        end else if (r_fcnt < FMAX) begin
                            n_frac = (r_frac << 3) + (r_frac << 1) + 60'(dig);
                            n_fcnt = r_fcnt + 5'd1;
                        end
                    end else if (i_ch == "." && !r_pt) begin
                        n_pt = 1'b1;
                    end else begin
                        has_close = 1'b1; close_tok = num_tok; lex_now = 1'b1;
                    end
                end
                ST_STR: begin
                    if (i_ch == "\"") begin
                        has_close = 1'b1; close_tok = str_tok; n_mode = ST_IDLE;
                    end else if (i_ch == 8'h0A) begin
                        has_close = 1'b1; close_tok = str_tok; lex_now = 1'b1;
                    end
                end
                ST_ID: begin
                    if (is_idch) begin
                        if (span_x[15:0] < 16'(IDENT_DEPTH) && span_x[PW+15:16] == '0) wr_ch = 1'b1;
                        else n_long = 1'b1;
                    end else begin
                        has_close = 1'b1; close_tok = id_tok; lex_now = 1'b1;
                    end
                end
                default: lex_now = 1'b1;
            endcase
            if (has_close && !lex_now) n_mode = ST_IDLE;
            if (lex_now) begin
                n_mode = ST_IDLE;
                if (is_dig) begin
                    n_mode = ST_NUM; n_start = r_pos; n_int = 63'(dig);
                    n_frac = '0; n_fcnt = '0; n_pt = 1'b0;
                end else if (i_ch == "\"") begin
                    n_mode = ST_STR; n_start = pos1;
                end else if (is_alpha) begin
                    n_mode = ST_ID; n_start = r_pos; n_long = 1'b0;
                end
                if (il_emit && i_ch == 8'h0A && r_line != 16'hFFFF) n_line = r_line + 16'd1;
            end
            if (has_close) begin
                o_pair.t0 = close_tok;
                o_pair.t1 = il_tok;
                o_pair.cnt = (lex_now && il_emit) ? 2'd2 : 2'd1;
            end else if (lex_now && il_emit) begin
                o_pair.t0 = il_tok; o_pair.cnt = 2'd1;
            end
            n_pos = pos_inc;
        end
    end

    assign o_push = i_acc && o_pair.cnt != 2'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= ST_IDLE; r_pos <= '0; r_line <= 16'd1; r_start <= '0;
            r_int <= '0; r_frac <= '0; r_fcnt <= '0; r_pt <= 1'b0; r_long <= 1'b0;
        end else if (i_acc) begin
            r_mode <= n_mode; r_pos <= n_pos; r_line <= n_line; r_start <= n_start;
            r_int <= n_int; r_frac <= n_frac; r_fcnt <= n_fcnt; r_pt <= n_pt;
            r_long <= n_long;
        end
    end

    // identifier characters, written at the scan offset
    always_ff @(posedge i_clk) begin
        if (i_acc && i_kind == IN_BYTE) begin
            if (lex_now && is_alpha) r_chars[0] <= i_ch;
            else if (wr_ch) r_chars[span_x[2:0]] <= i_ch;
        end
    end

endmodule

// ===== src/bst_queue.sv =====
// two-entry queue of token pairs between front and back
// depends on bst_pkg
module bst_queue import bst_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_pair i_pair,
    input  logic  i_pop,
    output logic  o_full,
    output logic  o_empty,
    output t_pair o_head
);
    t_pair      r_ent [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;

    assign o_full  = r_cnt == 2'd2;
    assign o_empty = r_cnt == 2'd0;
    assign o_head  = r_ent[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0; r_rp <= 1'b0; r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_ent[r_wp] <= i_pair;
    end

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3) else $error("queue count out of range");
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push) else $error("push into full queue");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_empty |-> !i_pop) else $error("pop from empty queue");

endmodule

// ===== src/bst_back.sv =====
// back end: splits queued pairs into single token words in an output register
// depends on bst_pkg
module bst_back import bst_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_empty,
    input  t_pair i_head,
    output logic  o_pop,
    output logic  o_valid,
    input  logic  i_ready,
    output t_tok  o_tok,
    output logic  o_last
);
    logic r_idx, r_valid, r_last;
    t_tok r_tok;
    logic load, last_now;

    assign load     = !i_empty && (!r_valid || i_ready);
    assign last_now = r_idx || i_head.cnt == 2'd1;
    assign o_pop    = load && last_now;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= 1'b0; r_valid <= 1'b0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_idx   <= !last_now;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_tok  <= r_idx ? i_head.t1 : i_head.t0;
            r_last <= last_now;
        end
    end

    assign o_valid = r_valid;
    assign o_tok   = r_tok;
    assign o_last  = r_last;

endmodule
